FILE: rtl/zbfa_pkg.sv
package zbfa_pkg;

  // Frame numbers are carried at this width: it holds any byte address >> 12
  // plus a run length, and any supported capacity.
  localparam int FRAME_W = 22;
  localparam int CNT_W   = 17;
  localparam int PCT_W   = 7;

  localparam logic [CNT_W-1:0] CNT_MAX  = '1;
  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

  localparam logic [2:0] OP_ALLOC_FRAME = 3'd0;
  localparam logic [2:0] OP_ALLOC_RUN   = 3'd1;
  localparam logic [2:0] OP_FREE_FRAME  = 3'd2;
  localparam logic [2:0] OP_FREE_RUN    = 3'd3;
  localparam logic [2:0] OP_MARK_USED   = 3'd4;
  localparam logic [2:0] OP_RELEASE     = 3'd5;
  localparam logic [2:0] OP_QUERY       = 3'd6;

  localparam logic [1:0] ZONE_ANY        = 2'd0;
  localparam logic [1:0] ZONE_PREFER_LOW = 2'd2;

  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_NO_MEMORY    = 3'd1;
  localparam logic [2:0] ST_MISALIGNED   = 3'd2;
  localparam logic [2:0] ST_DOUBLE_FREE  = 3'd3;
  localparam logic [2:0] ST_OUT_OF_RANGE = 3'd4;

  localparam logic [1:0] CFG_DMA_LIMIT = 2'd0;
  localparam logic [1:0] CFG_CEILING   = 2'd1;
  localparam logic [1:0] CFG_RAM_TOP   = 2'd2;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_START, S_SETUP, S_STEP, S_FILL, S_FLUSH, S_DIV, S_OUT
  } state_t;

  typedef enum logic [2:0] {
    P_SCAN1, P_SCAN2, P_RUN, P_MARKRUN, P_FREE, P_MARK, P_RELEASE, P_QUERY
  } phase_t;

  typedef enum logic [3:0] {
    ACT_NONE, ACT_FETCH, ACT_SCAN2, ACT_NEXTZONE, ACT_FAIL, ACT_FINISH,
    ACT_TAKE, ACT_RUNFOUND, ACT_STEP
  } act_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    return (c == CNT_MAX) ? c : c + 1'b1;
  endfunction

  function automatic logic [CNT_W-1:0] sat_dec(input logic [CNT_W-1:0] c);
    return (c == '0) ? c : c - 1'b1;
  endfunction

endpackage

FILE: rtl/zbfa_ram.sv
module zbfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/zbfa_div.sv
module zbfa_div import zbfa_pkg::*; #(
  parameter int DEN_W = 17,
  localparam int NUM_W = DEN_W + PCT_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [PCT_W-1:0] quot
);

  // Restoring division, one quotient bit per cycle; quotient never exceeds 100.
  logic [NUM_W-1:0] rem;
  logic [DEN_W-1:0] den_r;
  logic [2:0]       step;
  logic             running;
  logic [NUM_W-1:0] dsh;

  assign dsh = NUM_W'(den_r) << step;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else if (start) begin
      rem     <= num;
      den_r   <= den;
      step    <= 3'd6;
      running <= (den != '0);
      done    <= (den == '0);
      quot    <= (den == '0) ? PCT_FULL : '0;
    end else if (running) begin
      if (rem >= dsh) begin
        rem        <= rem - dsh;
        quot[step] <= 1'b1;
      end
      if (step == 3'd0) begin
        running <= 1'b0;
        done    <= 1'b1;
      end else begin
        step <= step - 3'd1;
      end
    end
  end

endmodule

FILE: rtl/zoned_bitmap_frame_allocator.sv
// Zoned bitmap frame allocator: one used bit per 4 KB frame, kept in a
// 32-bit-wide synchronous RAM, with a DMA zone and a normal zone.
// Input channel (in_valid / in_stall): one beat carries an operation and its
// operands. in_stall is low only while the engine is idle; a new beat is
// taken even while the previous result still sits in the output register.
// Output channel (out_valid / out_stall): exactly one result beat per input
// beat, held stable while out_stall is high. The engine parks on a finished
// result until the output register frees up.
// Config channel (cfg_valid / cfg_ready): cfg_ready is always high; index 0
// is the DMA limit, 1 the allocation ceiling, 2 the RAM top; index 3 is
// dropped. Write only while the block is idle.
// Operations walk the bitmap one frame at a time; each 32-frame word is
// brought into the working register (a read-modify-write cache of one
// word) before its frames are visited, and setup, write-back and the 7-step
// load percentage divider come on top. Searches and range walks thus scale
// with frames visited.
// Reset: the bitmap is swept to all-used, one word per cycle, across all
// (FRAME_CAPACITY+31)/32 words (2048 by default); in_stall stays high then.
module zoned_bitmap_frame_allocator import zbfa_pkg::*; #(
  parameter int FRAME_CAPACITY = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  operation,
  input  logic [1:0]  zone_mode,
  input  logic [31:0] phys_address,
  input  logic [31:0] byte_length,
  input  logic [16:0] frame_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] result_address,
  output logic [2:0]  status,
  output logic        is_used,
  output logic [16:0] free_total,
  output logic [16:0] free_dma,
  output logic [31:0] double_frees,
  output logic [6:0]  load_percent,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data
);

  localparam int WORDS = (FRAME_CAPACITY + 31) / 32;
  localparam int AW    = $clog2(WORDS);
  localparam int DEN_W = $clog2(FRAME_CAPACITY + 1);
  localparam int NUM_W = DEN_W + PCT_W;
  localparam logic [FRAME_W-1:0] CAP_F     = FRAME_W'(FRAME_CAPACITY);
  localparam logic [AW-1:0]      LAST_WORD = AW'(WORDS - 1);

  // configuration
  logic [CNT_W-1:0] dma_limit, ceiling, ram_top;
  logic [FRAME_W-1:0] dma_f, ceil_f, ram_f, dma_end;

  // latched operation
  logic [2:0]  op_r;
  logic [1:0]  mode_r;
  logic [31:0] addr_r, len_r;
  logic [CNT_W-1:0] cnt_r;

  // engine
  state_t state, state_next;
  phase_t phase;
  act_t   act;
  logic [FRAME_W-1:0] cur, endf, lo_r, from_r, begin_r;
  logic [CNT_W-1:0]   run;
  logic               zone, zone_low, dbl, oor;
  logic [31:0]        word;
  logic [AW-1:0]      widx, clr_idx;
  logic               wvalid, dirty;
  logic [31:0]        res_addr;
  logic [2:0]         res_status;
  logic               res_used;

  // allocator state
  logic [CNT_W-1:0] free_cnt, dma_cnt, dma_hint, norm_hint;
  logic [31:0]      dfc;

  // memory port
  logic          ram_we;
  logic [AW-1:0] ram_waddr, cur_idx;
  logic [31:0]   ram_wdata, ram_rdata;

  // helpers
  logic [4:0]         bit_pos;
  logic               hit, cur_bit, at_end, fallback, dma_first, run_hit;
  logic [FRAME_W-1:0] cur_inc;
  logic               low_s;
  logic [FRAME_W-1:0] lo_s, hi_s, hint_s, from_s;
  logic [FRAME_W-1:0] fa, free_end, mark_fe, rel_fs, rel_fe;
  logic [33:0]        mark_sum;
  logic [32:0]        rel_lo_sum, rel_hi_sum;
  logic [FRAME_W-1:0] used_f;
  logic [NUM_W-1:0]   div_num;
  logic               div_start, div_done;
  logic [PCT_W-1:0]   div_q;
  logic               out_free;

  // values above capacity act as capacity
  assign dma_f   = (FRAME_W'(dma_limit) > CAP_F) ? CAP_F : FRAME_W'(dma_limit);
  assign ceil_f  = (FRAME_W'(ceiling) > CAP_F) ? CAP_F : FRAME_W'(ceiling);
  assign ram_f   = (FRAME_W'(ram_top) > CAP_F) ? CAP_F : FRAME_W'(ram_top);
  assign dma_end = (dma_f < ceil_f) ? dma_f : ceil_f;

  assign cur_idx = cur[5 +: AW];
  assign bit_pos = cur[4:0];
  assign hit     = wvalid && (widx == cur_idx);
  assign cur_bit = word[bit_pos];
  assign at_end  = (cur >= endf);
  assign cur_inc = cur + 1'b1;
  assign run_hit = ({1'b0, run} + 18'd1) == {1'b0, cnt_r};

  assign dma_first = (mode_r != ZONE_ANY);
  assign fallback  = (mode_r == ZONE_ANY) || (mode_r == ZONE_PREFER_LOW);

  // zone window for the current search pass
  assign low_s  = zone ? !dma_first : dma_first;
  assign lo_s   = low_s ? FRAME_W'(1) : dma_f;
  assign hi_s   = low_s ? dma_end : ceil_f;
  assign hint_s = low_s ? FRAME_W'(dma_hint) : FRAME_W'(norm_hint);
  assign from_s = (hint_s >= lo_s && hint_s < hi_s) ? hint_s : lo_s;

  // range ends, computed without 32-bit wrap
  assign fa         = FRAME_W'(addr_r[31:12]);
  assign free_end   = fa + ((op_r == OP_FREE_FRAME) ? FRAME_W'(1) : FRAME_W'(cnt_r));
  assign mark_sum   = {2'b00, addr_r} + {2'b00, len_r} + 34'hFFF;
  assign mark_fe    = mark_sum[33:12];
  assign rel_lo_sum = {1'b0, addr_r} + 33'hFFF;
  assign rel_hi_sum = {1'b0, addr_r} + {1'b0, len_r};
  assign rel_fs     = FRAME_W'(rel_lo_sum[32:12]);
  assign rel_fe     = FRAME_W'(rel_hi_sum[32:12]);

  // load percentage numerator: used * 100
  assign used_f  = (FRAME_W'(free_cnt) > ceil_f) ? '0 : ceil_f - FRAME_W'(free_cnt);
  assign div_num = (NUM_W'(used_f) << 6) + (NUM_W'(used_f) << 5) + (NUM_W'(used_f) << 2);

  assign out_free  = !out_valid || !out_stall;
  assign cfg_ready = 1'b1;

  // per-frame decision
  always_comb begin
    act = ACT_NONE;
    if (state == S_STEP) begin
      case (phase)
        P_SCAN1: begin
          if (at_end) act = ACT_SCAN2;
          else if (!hit) act = ACT_FETCH;
          else if (!cur_bit) act = ACT_TAKE;
          else act = ACT_STEP;
        end
        P_SCAN2: begin
          if (at_end) act = (!zone && fallback) ? ACT_NEXTZONE : ACT_FAIL;
          else if (!hit) act = ACT_FETCH;
          else if (!cur_bit) act = ACT_TAKE;
          else act = ACT_STEP;
        end
        P_RUN: begin
          if (at_end) act = (!zone && fallback) ? ACT_NEXTZONE : ACT_FAIL;
          else if (!hit) act = ACT_FETCH;
          else if (!cur_bit && run_hit) act = ACT_RUNFOUND;
          else act = ACT_STEP;
        end
        P_FREE: begin
          if (at_end) act = ACT_FINISH;
          else if (cur >= ceil_f) act = ACT_FINISH;  // rest is out of range
          else if (cur == '0) act = ACT_STEP;
          else if (!hit) act = ACT_FETCH;
          else act = ACT_STEP;
        end
        P_QUERY: begin
          if (at_end) act = ACT_FINISH;
          else if (!hit) act = ACT_FETCH;
          else act = ACT_FINISH;
        end
        default: begin
          if (at_end) act = ACT_FINISH;
          else if (!hit) act = ACT_FETCH;
          else act = ACT_STEP;
        end
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (clr_idx == LAST_WORD) state_next = S_IDLE;
      S_IDLE:  if (in_valid) state_next = S_START;
      S_START: begin
        case (op_r)
          OP_ALLOC_FRAME, OP_ALLOC_RUN: begin
            state_next = (op_r == OP_ALLOC_RUN && cnt_r == '0) ? S_FLUSH : S_SETUP;
          end
          OP_FREE_FRAME, OP_FREE_RUN: begin
            state_next = (addr_r[11:0] != 12'h000) ? S_FLUSH : S_STEP;
          end
          OP_MARK_USED, OP_RELEASE, OP_QUERY: state_next = S_STEP;
          default: state_next = S_FLUSH;
        endcase
      end
      S_SETUP: state_next = S_STEP;
      S_STEP: begin
        case (act)
          ACT_FETCH:    state_next = S_FILL;
          ACT_NEXTZONE: state_next = S_SETUP;
          ACT_FAIL, ACT_FINISH, ACT_TAKE: state_next = S_FLUSH;
          default:      state_next = S_STEP;
        endcase
      end
      S_FILL:  state_next = S_STEP;
      S_FLUSH: state_next = S_DIV;
      S_DIV:   if (div_done) state_next = S_OUT;
      S_OUT:   if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // memory and handshake drive
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = widx;
    ram_wdata = word;
    in_stall  = (state != S_IDLE);
    div_start = (state == S_FLUSH);
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_idx;
        ram_wdata = '1;
      end
      S_STEP:  ram_we = (act == ACT_FETCH) && dirty;  // evict before refill
      S_FLUSH: ram_we = dirty;
      default: ram_we = 1'b0;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dma_limit <= 17'd4096;
      ceiling   <= 17'd65536;
      ram_top   <= 17'd65536;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DMA_LIMIT: dma_limit <= cfg_data;
        CFG_CEILING:   ceiling   <= cfg_data;
        CFG_RAM_TOP:   ram_top   <= cfg_data;
        default: ;
      endcase
    end
  end

  // control and allocator state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      wvalid    <= 1'b0;
      dirty     <= 1'b0;
      free_cnt  <= '0;
      dma_cnt   <= '0;
      dma_hint  <= 17'd1;
      norm_hint <= '0;
      dfc       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      // a new result may replace the one leaving in the same cycle
      if (state == S_OUT && out_free) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;

      case (state)
        S_CLEAR: clr_idx <= clr_idx + 1'b1;
        S_FILL: begin
          wvalid <= 1'b1;
        end
        S_STEP: begin
          case (act)
            ACT_FETCH: begin
              wvalid <= 1'b0;
              dirty  <= 1'b0;
            end
            ACT_TAKE: begin
              dirty    <= 1'b1;
              free_cnt <= sat_dec(free_cnt);
              if (cur < dma_f) dma_cnt <= sat_dec(dma_cnt);
              if (zone_low) dma_hint <= cur_inc[CNT_W-1:0];
              else norm_hint <= cur_inc[CNT_W-1:0];
            end
            ACT_STEP: begin
              case (phase)
                P_MARKRUN: begin
                  dirty    <= 1'b1;
                  free_cnt <= sat_dec(free_cnt);
                  if (cur < dma_f) dma_cnt <= sat_dec(dma_cnt);
                end
                P_MARK: begin
                  if (!cur_bit) begin
                    dirty    <= 1'b1;
                    free_cnt <= sat_dec(free_cnt);
                    if (cur < dma_f) dma_cnt <= sat_dec(dma_cnt);
                  end
                end
                P_RELEASE, P_FREE: begin
                  // release may clear frame zero; a free never does
                  if (phase == P_FREE && cur != '0 && !cur_bit) begin
                    dfc <= dfc + 1'b1;
                  end else if ((phase == P_RELEASE || cur != '0) && cur_bit) begin
                    dirty    <= 1'b1;
                    free_cnt <= sat_inc(free_cnt);
                    if (cur < dma_f) begin
                      dma_cnt <= sat_inc(dma_cnt);
                      if (cur < FRAME_W'(dma_hint)) dma_hint <= cur[CNT_W-1:0];
                    end else if (cur < FRAME_W'(norm_hint)) begin
                      norm_hint <= cur[CNT_W-1:0];
                    end
                  end
                end
                default: ;
              endcase
            end
            default: ;
          endcase
        end
        S_FLUSH: begin
          wvalid <= 1'b0;
          dirty  <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // payload and engine datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        op_r       <= operation;
        mode_r     <= zone_mode;
        addr_r     <= phys_address;
        len_r      <= byte_length;
        cnt_r      <= frame_count;
        res_addr   <= '0;
        res_status <= ST_OK;
        res_used   <= 1'b0;
      end
      S_START: begin
        zone <= 1'b0;
        dbl  <= 1'b0;
        oor  <= 1'b0;
        case (op_r)
          OP_ALLOC_FRAME, OP_ALLOC_RUN: begin
            if (op_r == OP_ALLOC_RUN && cnt_r == '0) res_status <= ST_OUT_OF_RANGE;
          end
          OP_FREE_FRAME, OP_FREE_RUN: begin
            if (addr_r[11:0] != 12'h000) res_status <= ST_MISALIGNED;
            phase <= P_FREE;
            cur   <= fa;
            endf  <= free_end;
          end
          OP_MARK_USED: begin
            phase <= P_MARK;
            cur   <= fa;
            endf  <= (mark_fe < ram_f) ? mark_fe : ram_f;
          end
          OP_RELEASE: begin
            phase <= P_RELEASE;
            cur   <= rel_fs;
            endf  <= (rel_fe < ceil_f) ? rel_fe : ceil_f;
          end
          OP_QUERY: begin
            phase <= P_QUERY;
            cur   <= fa;
            endf  <= ram_f;
          end
          default: res_status <= ST_OUT_OF_RANGE;
        endcase
      end
      S_SETUP: begin
        lo_r     <= lo_s;
        from_r   <= from_s;
        zone_low <= low_s;
        endf     <= hi_s;
        run      <= '0;
        begin_r  <= lo_s;
        if (op_r == OP_ALLOC_FRAME) begin
          phase <= P_SCAN1;
          cur   <= from_s;
        end else begin
          phase <= P_RUN;
          cur   <= lo_s;
        end
      end
      S_FILL: begin
        word <= ram_rdata;
        widx <= cur_idx;
      end
      S_STEP: begin
        case (act)
          ACT_SCAN2: begin
            phase <= P_SCAN2;
            cur   <= lo_r;
            endf  <= from_r;
          end
          ACT_NEXTZONE: zone <= 1'b1;
          ACT_FAIL:     res_status <= ST_NO_MEMORY;
          ACT_TAKE: begin
            word[bit_pos] <= 1'b1;
            res_addr      <= 32'(cur) << 12;
          end
          ACT_RUNFOUND: begin
            phase <= P_MARKRUN;
            cur   <= begin_r;
            endf  <= begin_r + FRAME_W'(cnt_r);
          end
          ACT_FINISH: begin
            case (phase)
              P_MARKRUN: res_addr <= 32'(begin_r) << 12;
              P_FREE: begin
                if (dbl) res_status <= ST_DOUBLE_FREE;
                else if (oor || !at_end) res_status <= ST_OUT_OF_RANGE;
                else res_status <= ST_OK;
              end
              P_QUERY: res_used <= !at_end && cur_bit;
              default: ;
            endcase
          end
          ACT_STEP: begin
            cur <= cur_inc;
            case (phase)
              P_RUN: begin
                if (cur_bit) begin
                  run     <= '0;
                  begin_r <= cur_inc;
                end else begin
                  run <= run + 1'b1;
                end
              end
              P_MARKRUN, P_MARK: word[bit_pos] <= 1'b1;
              P_RELEASE: word[bit_pos] <= 1'b0;
              P_FREE: begin
                if (cur == '0) oor <= 1'b1;
                else if (!cur_bit) dbl <= 1'b1;
                else word[bit_pos] <= 1'b0;
              end
              default: ;
            endcase
          end
          default: ;
        endcase
      end
      S_OUT: begin
        if (out_free) begin
          result_address <= res_addr;
          status         <= res_status;
          is_used        <= res_used;
          free_total     <= free_cnt;
          free_dma       <= dma_cnt;
          double_frees   <= dfc;
          load_percent   <= div_q;
        end
      end
      default: ;
    endcase
  end

  zbfa_ram #(
    .WIDTH (32),
    .DEPTH (WORDS)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cur_idx),
    .rdata (ram_rdata)
  );

  zbfa_div #(
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (DEN_W'(ceil_f)),
    .done  (div_done),
    .quot  (div_q)
  );

endmodule
